>>> src/mxs_pkg.sv
// Shared types and constants for the max stack block.
// No dependencies; imported by every module of the block.
package mxs_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned OccW         = 5;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_POP_MAX = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [DataW-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] popped_value;
    logic signed [DataW-1:0] top_value;
    logic signed [DataW-1:0] max_value;
    logic [OccW-1:0]         occupancy;
    logic [1:0]              status;
  } rsp_t;

  // Control of the shared compare unit
  typedef struct packed {
    logic en;     // present one entry this cycle
    logic first;  // entry starts a new search
  } cmp_ctl_t;

endpackage

>>> src/mxs_mem.sv
// Entry storage for the max stack: one write port, one registered read port.
// Depends on mxs_pkg for the data width.
module mxs_mem #(
  parameter int unsigned DEPTH = mxs_pkg::DefaultDepth,
  parameter int unsigned AW    = 4
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic signed [mxs_pkg::DataW-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [AW-1:0]                    raddr_i,
  output logic signed [mxs_pkg::DataW-1:0] rdata_o
);
  import mxs_pkg::*;

  logic signed [DataW-1:0] mem_q [DEPTH];
  logic signed [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mxs_cmp.sv
// Shared signed compare unit: tracks the largest entry seen and its index,
// the later (higher) entry winning ties. Depends on mxs_pkg.
module mxs_cmp #(
  parameter int unsigned AW = 4
) (
  input  logic                             clk_i,
  input  mxs_pkg::cmp_ctl_t                ctl_i,
  input  logic [AW-1:0]                    idx_i,
  input  logic signed [mxs_pkg::DataW-1:0] data_i,
  output logic signed [mxs_pkg::DataW-1:0] best_o,
  output logic [AW-1:0]                    best_idx_o
);
  import mxs_pkg::*;

  logic signed [DataW-1:0] best_q;
  logic [AW-1:0]           best_idx_q;
  logic                    take;

  // Take the new entry when it starts a search or the held one is not strictly larger
  assign take = ctl_i.en && (ctl_i.first || !(best_q > data_i));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q     <= data_i;
      best_idx_q <= idx_i;
    end
  end

  assign best_o     = best_q;
  assign best_idx_o = best_idx_q;

endmodule

>>> src/max_stack_top.sv
// Max stack top level: LIFO of signed 32-bit values with push, pop, pop-max.
// Push: the result is registered in the done state that follows acceptance.
// Pop rescans the entries left; pop-max may shift them down first, then rescan;
// a shift pass and a rescan share one memory read port and one compare unit.
// One item at a time; the next item is taken once the result is registered.
// Reset (async, active low) empties the stack; entry storage is not cleared.
module max_stack_top #(
  parameter int unsigned DEPTH = mxs_pkg::DefaultDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  mxs_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output mxs_pkg::rsp_t rsp_o
);
  import mxs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e  state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic signed [DataW-1:0] popped_q, popped_d;
  logic signed [DataW-1:0] top_q, top_d;
  status_e status_q, status_d;
  logic    rsp_valid_q, rsp_valid_d;
  rsp_t    rsp_q, rsp_d;

  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic signed [DataW-1:0] mem_wdata, mem_rdata;

  cmp_ctl_t                cmp_ctl;
  logic [AW-1:0]           cmp_idx;
  logic signed [DataW-1:0] cmp_data;
  logic signed [DataW-1:0] best;
  logic [AW-1:0]           best_idx;

  mxs_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  mxs_cmp #(.AW(AW)) u_cmp (
    .clk_i     (clk_i),
    .ctl_i     (cmp_ctl),
    .idx_i     (cmp_idx),
    .data_i    (cmp_data),
    .best_o    (best),
    .best_idx_o(best_idx)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    popped_d    = popped_q;
    top_d       = top_q;
    status_d    = status_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    rsp_d       = rsp_q;
    req_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = pend_addr_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q[AW-1:0];
    cmp_ctl     = '0;
    cmp_idx     = pend_addr_q;
    cmp_data    = mem_rdata;

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          popped_d = '0;
          status_d = STAT_OK;
          state_d  = ST_DONE;
          case (req_i.req_type) inside
            REQ_PUSH: begin
              if (count_q >= CW'(DEPTH)) begin
                status_d = STAT_FULL;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = count_q[AW-1:0];
                mem_wdata     = req_i.push_value;
                count_d       = count_q + CW'(1);
                top_d         = req_i.push_value;
                cmp_ctl.en    = 1'b1;
                cmp_ctl.first = (count_q == '0);
                cmp_idx       = count_q[AW-1:0];
                cmp_data      = req_i.push_value;
              end
            end
            REQ_POP, REQ_POP_MAX: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                if (req_i.req_type == REQ_POP) begin
                  popped_d = top_q;
                end else begin
                  popped_d = best;
                end
                if (req_i.req_type == REQ_POP_MAX &&
                    (CW'(best_idx) + CW'(1)) < count_q) begin
                  // close the gap left by the removed entry
                  state_d = ST_SHIFT;
                  ptr_d   = CW'(best_idx) + CW'(1);
                end else if (count_q > CW'(1)) begin
                  state_d = ST_SCAN;
                  ptr_d   = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_SHIFT: begin
        // count_q already holds the reduced count, the last old entry index
        if (pend_q) begin
          mem_we = 1'b1;
        end
        if (ptr_q <= count_q) begin
          mem_re      = 1'b1;
          ptr_d       = ptr_q + CW'(1);
          pend_d      = 1'b1;
          pend_addr_d = AW'(ptr_q - CW'(1));
        end else if (!pend_q) begin
          state_d = ST_SCAN;
          ptr_d   = '0;
        end
      end

      ST_SCAN: begin
        if (pend_q) begin
          cmp_ctl.en    = 1'b1;
          cmp_ctl.first = (pend_addr_q == '0);
          if (CW'(pend_addr_q) == count_q - CW'(1)) begin
            top_d = mem_rdata;
          end
        end
        if (ptr_q < count_q) begin
          mem_re      = 1'b1;
          ptr_d       = ptr_q + CW'(1);
          pend_d      = 1'b1;
          pend_addr_d = ptr_q[AW-1:0];
        end else if (!pend_q) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d        = 1'b1;
          rsp_d.popped_value = popped_q;
          rsp_d.top_value    = (count_q != '0) ? top_q : '0;
          rsp_d.max_value    = (count_q != '0) ? best : '0;
          rsp_d.occupancy    = OccW'(count_q);
          rsp_d.status       = status_q;
          state_d            = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    popped_q    <= popped_d;
    top_q       <= top_d;
    status_q    <= status_d;
    rsp_q       <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
